[design/drbm_pkg.sv]
`default_nettype none

package drbm_pkg;

  localparam int FRAC_BITS = 12;
  // Pi in Q.FRAC_BITS, rounded from a Q.17 constant.
  localparam int PI_Q = (411775 + (1 << (16 - FRAC_BITS))) >> (17 - FRAC_BITS);

  localparam int DIFF_W     = 17;
  localparam int SQ_W       = 34;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int NUM_W      = 16 + FRAC_BITS;
  localparam int REM_W      = 16;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int IDX_W      = 12;

  typedef logic        [1:0]  charge_t;
  typedef logic signed [14:0] phi_t;
  typedef logic signed [15:0] eta_t;
  typedef logic        [15:0] pt_t;
  typedef logic        [7:0]  tol_t;
  typedef logic [IDX_W-1:0]   index_t;
  typedef logic        [15:0] dr_t;
  typedef logic signed [23:0] dpt_t;
  typedef logic        [2:0]  cfg_idx_t;
  typedef logic        [15:0] cfg_data_t;

  localparam logic signed [DIFF_W-1:0] PI_D     = DIFF_W'(PI_Q);
  localparam logic signed [DIFF_W-1:0] TWO_PI_D = DIFF_W'(2 * PI_Q);

  localparam dpt_t DPT_MAX = 24'sh7FFFFF;
  localparam dpt_t DPT_MIN = 24'sh800000;
  localparam dr_t  DR_MAX  = 16'hFFFF;

  localparam cfg_idx_t CFG_REF_CHARGE = 3'd0;
  localparam cfg_idx_t CFG_REF_PHI    = 3'd1;
  localparam cfg_idx_t CFG_REF_ETA    = 3'd2;
  localparam cfg_idx_t CFG_REF_PT     = 3'd3;
  localparam cfg_idx_t CFG_TIE_TOL    = 3'd4;

  typedef struct packed {
    phi_t ref_phi;
    phi_t cand_phi;
    eta_t ref_eta;
    eta_t cand_eta;
    pt_t  ref_pt;
    pt_t  cand_pt;
  } score_req_t;

  typedef struct packed {
    dr_t  dr;
    dpt_t dpt;
  } score_res_t;

endpackage

`default_nettype wire

[design/drbm_if.sv]
`default_nettype none

interface drbm_cand_if;
  logic             valid;
  logic             ready;
  drbm_pkg::charge_t cand_charge;
  drbm_pkg::phi_t    cand_phi;
  drbm_pkg::eta_t    cand_eta;
  drbm_pkg::pt_t     cand_pt;
  logic             last;

  modport source (output valid, cand_charge, cand_phi, cand_eta, cand_pt, last,
                  input ready);
  modport sink (input valid, cand_charge, cand_phi, cand_eta, cand_pt, last,
                output ready);
endinterface

interface drbm_res_if;
  logic             valid;
  logic             ready;
  logic             found;
  drbm_pkg::index_t best_index;
  drbm_pkg::dr_t    best_dr;
  drbm_pkg::dpt_t   best_dpt;

  modport source (output valid, found, best_index, best_dr, best_dpt, input ready);
  modport sink (input valid, found, best_index, best_dr, best_dpt, output ready);
endinterface

interface drbm_cfg_if;
  logic                valid;
  logic                ready;
  drbm_pkg::cfg_idx_t  index;
  drbm_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/delta_r_best_match_search.sv]
// Channel | Dir | Payload                                          | Transfer
// cand    | in  | cand_charge, cand_phi, cand_eta, cand_pt, last   | valid & ready
// res     | out | found, best_index, best_dr, best_dpt             | valid & ready
// cfg     | in  | index, data (register write)                     | valid & ready
//
// A candidate of another charge is not scored; it advances the position. A same-charge
// candidate holds the input while it is scored: set-up, squaring on the multiplier, then 17
// root steps, 28 divide steps and one rounding step, all on one shared subtract-compare unit.
// After the last candidate, the result register loads before new candidates are taken.
// Reset is synchronous and active high; it restores the register defaults.
// A waiting result does not block candidates, only the next result.
`default_nettype none

module delta_r_best_match_search #(
  parameter int MAX_CANDIDATES = 4096
) (
  input wire logic    clk,
  input wire logic    rst,
  drbm_cand_if.sink   cand,
  drbm_res_if.source  res,
  drbm_cfg_if.sink    cfg
);

  localparam int PW = $clog2(MAX_CANDIDATES);
  localparam int RW = drbm_pkg::REM_W;

  typedef enum logic [1:0] {T_IDLE, T_SCORE, T_EMIT} state_t;

  state_t state;

  drbm_pkg::charge_t ref_charge;
  drbm_pkg::phi_t    ref_phi;
  drbm_pkg::eta_t    ref_eta;
  drbm_pkg::pt_t     ref_pt;
  drbm_pkg::tol_t    tie_tol;

  logic                 have_best;
  drbm_pkg::dr_t        kept_dr;
  drbm_pkg::dpt_t       kept_dpt;
  logic [PW-1:0]        kept_index;
  logic [PW-1:0]        position;
  logic                 last_q;

  logic                 score_start;
  drbm_pkg::score_req_t score_req;
  drbm_pkg::score_res_t score_res;
  logic                 score_done;

  logic                 out_valid;
  logic                 out_found;
  drbm_pkg::index_t     out_index;
  drbm_pkg::dr_t        out_dr;
  drbm_pkg::dpt_t       out_dpt;

  logic                 cand_xfer;
  logic                 same_charge;
  logic                 emit;
  logic [PW-1:0]        position_next;
  logic signed [RW:0]   ddr;
  logic signed [RW:0]   ddr_abs;
  logic                 take_new;
  logic [31:0]          kept_index_ext;

  assign cand.ready = (state == T_IDLE);
  assign cfg.ready  = 1'b1;
  assign cand_xfer  = cand.valid && cand.ready;
  assign same_charge = (cand.cand_charge == ref_charge);
  // The result register loads when it is free or is being emptied.
  assign emit       = (state == T_EMIT) && (!out_valid || res.ready);

  assign position_next = (position == PW'(MAX_CANDIDATES - 1)) ? '0 : position + 1'b1;

  always_comb begin
    ddr     = {1'b0, score_res.dr} - {1'b0, kept_dr};
    ddr_abs = ddr[RW] ? -ddr : ddr;
    take_new = !have_best || ddr[RW] ||
               ((ddr_abs[RW-1:0] < RW'(tie_tol)) && (score_res.dpt < kept_dpt));
    kept_index_ext = 32'(kept_index);
  end

  assign res.valid      = out_valid;
  assign res.found      = out_found;
  assign res.best_index = out_index;
  assign res.best_dr    = out_dr;
  assign res.best_dpt   = out_dpt;

  drbm_score u_score (
    .clk   (clk),
    .rst   (rst),
    .start (score_start),
    .req   (score_req),
    .res   (score_res),
    .done  (score_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_charge <= '0;
      ref_phi    <= '0;
      ref_eta    <= '0;
      ref_pt     <= 16'd1;
      tie_tol    <= 8'd4;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        drbm_pkg::CFG_REF_CHARGE: ref_charge <= cfg.data[1:0];
        drbm_pkg::CFG_REF_PHI:    ref_phi    <= cfg.data[14:0];
        drbm_pkg::CFG_REF_ETA:    ref_eta    <= cfg.data;
        drbm_pkg::CFG_REF_PT:     ref_pt     <= cfg.data;
        drbm_pkg::CFG_TIE_TOL:    tie_tol    <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      score_start <= 1'b0;
      have_best   <= 1'b0;
      kept_dr     <= '0;
      kept_dpt    <= '0;
      kept_index  <= '0;
      position    <= '0;
      out_valid   <= 1'b0;
    end else begin
      score_start <= cand_xfer && same_charge;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (cand_xfer) begin
            last_q <= cand.last;
            if (same_charge) begin
              score_req   <= '{ref_phi: ref_phi, cand_phi: cand.cand_phi,
                               ref_eta: ref_eta, cand_eta: cand.cand_eta,
                               ref_pt: ref_pt, cand_pt: cand.cand_pt};
              state       <= T_SCORE;
            end else begin
              position <= position_next;
              if (cand.last) begin
                state <= T_EMIT;
              end
            end
          end
        end
        T_SCORE: begin
          if (score_done) begin
            if (take_new) begin
              have_best  <= 1'b1;
              kept_dr    <= score_res.dr;
              kept_dpt   <= score_res.dpt;
              kept_index <= position;
            end
            position <= position_next;
            state    <= last_q ? T_EMIT : T_IDLE;
          end
        end
        T_EMIT: begin
          if (emit) begin
            out_found  <= have_best;
            out_index  <= have_best ? kept_index_ext[drbm_pkg::IDX_W-1:0] : '0;
            out_dr     <= have_best ? kept_dr : '0;
            out_dpt    <= have_best ? kept_dpt : '0;
            have_best  <= 1'b0;
            kept_dr    <= '0;
            kept_dpt   <= '0;
            kept_index <= '0;
            position   <= '0;
            state      <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/drbm_score.sv]
`default_nettype none

module drbm_score (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire drbm_pkg::score_req_t req,
  output drbm_pkg::score_res_t      res,
  output logic                      done
);

  localparam int DW = drbm_pkg::DIFF_W;
  localparam int SW = drbm_pkg::SQ_W;
  localparam int NW = drbm_pkg::NUM_W;
  localparam int RW = drbm_pkg::REM_W;
  localparam int CW = drbm_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ_PHI, S_SQ_ETA, S_SQRT, S_DIV, S_FIN
  } state_t;

  state_t state;
  logic [CW-1:0] cnt;
  logic signed [DW-1:0] dphi, deta;
  logic [SW-1:0] acc, root, sbit;
  logic [NW-1:0] num;
  logic [RW-1:0] rem, divisor;
  logic          neg;

  logic signed [DW-1:0] dphi_raw, dphi_wrap, deta_raw, pt_diff, pt_mag_full;
  logic [RW-1:0] pt_ref;
  logic signed [DW-1:0] mul_op;
  logic signed [2*DW-1:0] prod;
  logic [SW-1:0] sub_a, sub_b;
  logic [SW:0]   sub_d;
  logic          sub_ge;
  logic [RW:0]   shifted;
  logic [RW+1:0] dr_round;
  logic [NW-1:0] quot;
  logic          quot_big;

  // Operand set-up at capture: wrapped azimuth difference, eta difference and
  // the magnitude of the pt difference scaled up for the divide.
  always_comb begin
    dphi_raw = {{2{req.ref_phi[14]}}, req.ref_phi} - {{2{req.cand_phi[14]}}, req.cand_phi};
    if (dphi_raw > drbm_pkg::PI_D) begin
      dphi_wrap = dphi_raw - drbm_pkg::TWO_PI_D;
    end else if (dphi_raw < -drbm_pkg::PI_D) begin
      dphi_wrap = dphi_raw + drbm_pkg::TWO_PI_D;
    end else begin
      dphi_wrap = dphi_raw;
    end
    deta_raw    = {req.ref_eta[15], req.ref_eta} - {req.cand_eta[15], req.cand_eta};
    pt_ref      = (req.ref_pt == '0) ? RW'(1) : req.ref_pt;
    pt_diff     = {1'b0, req.cand_pt} - {1'b0, pt_ref};
    pt_mag_full = pt_diff[DW-1] ? -pt_diff : pt_diff;
  end

  assign mul_op = (state == S_SQ_PHI) ? dphi : deta;
  assign prod   = mul_op * mul_op;

  assign shifted = {rem, num[NW-1]};

  // The one subtract-and-compare unit, shared by the root, the divide and the
  // final rounding.
  always_comb begin
    case (state)
      S_SQRT: begin
        sub_a = acc;
        sub_b = root + sbit;
      end
      S_DIV: begin
        sub_a = SW'(shifted);
        sub_b = SW'(divisor);
      end
      default: begin
        sub_a = root;
        sub_b = acc;
      end
    endcase
    sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge = ~sub_d[SW];
  end

  always_comb begin
    // The remainder exceeds the root exactly when root - remainder borrows.
    dr_round = (RW + 2)'(root) + (RW + 2)'(!sub_ge);
    quot     = num;
    quot_big = |quot[NW-1:23];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            dphi    <= dphi_wrap;
            deta    <= deta_raw;
            num     <= {pt_mag_full[RW-1:0], {(NW - RW){1'b0}}};
            neg     <= pt_diff[DW-1];
            divisor <= pt_ref;
            state   <= S_SQ_PHI;
          end
        end
        S_SQ_PHI: begin
          acc   <= prod;
          state <= S_SQ_ETA;
        end
        S_SQ_ETA: begin
          acc   <= acc + prod;
          root  <= '0;
          sbit  <= SW'(1) << (SW - 2);
          cnt   <= CW'(drbm_pkg::SQRT_STEPS - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sub_ge) begin
            acc  <= sub_d[SW-1:0];
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          if (cnt == '0) begin
            rem   <= '0;
            cnt   <= CW'(NW - 1);
            state <= S_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV: begin
          rem <= sub_ge ? sub_d[RW-1:0] : shifted[RW-1:0];
          num <= {num[NW-2:0], sub_ge};
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          res.dr <= (dr_round[RW+1:RW] != 2'b00) ? drbm_pkg::DR_MAX : dr_round[RW-1:0];
          if (neg) begin
            res.dpt <= quot_big ? drbm_pkg::DPT_MIN : -$signed(quot[23:0]);
          end else begin
            res.dpt <= quot_big ? drbm_pkg::DPT_MAX : $signed(quot[23:0]);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/drbm_checker.sv]
`default_nettype none

module drbm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           cand_valid,
  input wire logic           cand_ready,
  input wire logic           cand_last,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire logic           res_found,
  input wire drbm_pkg::index_t res_best_index,
  input wire drbm_pkg::dr_t    res_best_dr,
  input wire drbm_pkg::dpt_t   res_best_dpt
);

  // A stalled result keeps its valid and its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable(res_found) && $stable(res_best_index) &&
      $stable(res_best_dr) && $stable(res_best_dpt))
    else $error("result changed while stalled");

  a_res_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

  // A collection without a match reports all-zero fields.
  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |->
      res_best_index == '0 && res_best_dr == '0 && res_best_dpt == '0)
    else $error("non-zero fields without a match");

  // The pt difference relative to the reference can never fall below minus one.
  a_dpt_floor: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_found |-> res_best_dpt >= -24'sd4096)
    else $error("relative pt difference below minus one");

  // Closing a collection always takes the block away from the input.
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    cand_valid && cand_ready && cand_last |=> !cand_ready)
    else $error("ready stayed high after the last candidate");

endmodule

bind delta_r_best_match_search drbm_checker u_drbm_checker (
  .clk            (clk),
  .rst            (rst),
  .cand_valid     (cand.valid),
  .cand_ready     (cand.ready),
  .cand_last      (cand.last),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_found      (res.found),
  .res_best_index (res.best_index),
  .res_best_dr    (res.best_dr),
  .res_best_dpt   (res.best_dpt)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT    = 40;

  // Indexes that decode to no register at all.
  localparam drbm_pkg::cfg_idx_t CFG_UNMAPPED_FIRST = 3'd5;
  localparam drbm_pkg::cfg_idx_t CFG_UNMAPPED_LAST  = 3'd7;

  typedef struct packed {
    drbm_pkg::charge_t charge;
    drbm_pkg::phi_t    phi;
    drbm_pkg::eta_t    eta;
    drbm_pkg::pt_t     pt;
    logic              last;
  } cand_t;

  typedef struct packed {
    logic             found;
    drbm_pkg::index_t index;
    drbm_pkg::dr_t    dr;
    drbm_pkg::dpt_t   dpt;
  } match_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_CAND} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    drbm_pkg::cfg_idx_t  idx;
    drbm_pkg::cfg_data_t data;
    cand_t               cand;
    logic                typed;
    match_t              want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  drbm_cand_if cand_ch ();
  drbm_res_if  res_ch ();
  drbm_cfg_if  cfg_ch ();

  delta_r_best_match_search i_dut (
    .clk (clk),
    .rst (rst),
    .cand(cand_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor copy of the registers and of the running best match.
  drbm_pkg::charge_t ref_charge_r = '0;
  drbm_pkg::phi_t    ref_phi_r    = '0;
  drbm_pkg::eta_t    ref_eta_r    = '0;
  drbm_pkg::pt_t     ref_pt_r     = 16'd1;
  drbm_pkg::tol_t    tie_tol_r    = 8'd4;
  logic              have_best    = 1'b0;
  drbm_pkg::dr_t     kept_dr      = '0;
  drbm_pkg::dpt_t    kept_dpt     = '0;
  drbm_pkg::index_t  kept_index   = '0;
  drbm_pkg::index_t  stream_pos   = '0;

  match_t pending_matches[$];
  match_t seen_want;

  int  errors       = 0;
  int  cands_sent   = 0;
  int  cands_random = 0;
  int  results_seen = 0;
  int  reg_writes   = 0;
  int  quiet_cycles = 0;
  int  ready_hold   = 0;
  int  stall_len;
  bit  no_stall     = 1'b0;
  bit  busy         = 1'b0;

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic int idle_len();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Integer square root, rounded to nearest.
  function automatic longint root_nearest(input longint s);
    longint r;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= s) r += longint'(1) << b;
    end
    if (s - r * r > r) r += 1;
    return r;
  endfunction

  function automatic void predict_match(input cand_t c, output match_t m, output bit closes);
    longint dphi, deta, root, pt_ref, dpt, dr_gap;
    drbm_pkg::dr_t dr;
    m = '0;
    closes = c.last;
    if (c.charge == ref_charge_r) begin
      dphi = longint'(ref_phi_r) - longint'(c.phi);
      if (dphi > drbm_pkg::PI_Q) dphi -= 2 * drbm_pkg::PI_Q;
      else if (dphi < -drbm_pkg::PI_Q) dphi += 2 * drbm_pkg::PI_Q;
      deta = longint'(ref_eta_r) - longint'(c.eta);
      root = root_nearest(dphi * dphi + deta * deta);
      dr = (root > 65535) ? drbm_pkg::DR_MAX : drbm_pkg::dr_t'(root);
      pt_ref = (ref_pt_r == 0) ? longint'(1) : longint'(ref_pt_r);
      dpt = ((longint'(c.pt) - pt_ref) * (longint'(1) << drbm_pkg::FRAC_BITS)) / pt_ref;
      if (dpt > longint'(drbm_pkg::DPT_MAX)) dpt = longint'(drbm_pkg::DPT_MAX);
      if (dpt < longint'(drbm_pkg::DPT_MIN)) dpt = longint'(drbm_pkg::DPT_MIN);
      dr_gap = longint'(dr) - longint'(kept_dr);
      if (dr_gap < 0) dr_gap = -dr_gap;
      if (!have_best || dr < kept_dr ||
          (dr_gap < longint'(tie_tol_r) && dpt < longint'(kept_dpt))) begin
        have_best  = 1'b1;
        kept_dr    = dr;
        kept_dpt   = drbm_pkg::dpt_t'(dpt);
        kept_index = stream_pos;
      end
    end
    stream_pos = stream_pos + 1'b1;
    if (c.last) begin
      if (have_best) m = '{1'b1, kept_index, kept_dr, kept_dpt};
      have_best  = 1'b0;
      kept_dr    = '0;
      kept_dpt   = '0;
      kept_index = '0;
      stream_pos = '0;
    end
  endfunction

  function automatic row_t cand_row(input int ch, input int phi, input int eta, input int pt,
                                    input bit last);
    row_t r;
    r = '0;
    r.kind = ROW_CAND;
    r.cand = '{drbm_pkg::charge_t'(ch), drbm_pkg::phi_t'(phi), drbm_pkg::eta_t'(eta),
               drbm_pkg::pt_t'(pt), last};
    return r;
  endfunction

  function automatic row_t typed_row(input int ch, input int phi, input int eta, input int pt,
                                     input bit last, input bit found, input int idx,
                                     input int dr, input int dpt);
    row_t r;
    r = cand_row(ch, phi, eta, pt, last);
    r.typed = 1'b1;
    r.want = '{found, drbm_pkg::index_t'(idx), drbm_pkg::dr_t'(dr), drbm_pkg::dpt_t'(dpt)};
    return r;
  endfunction

  function automatic row_t cfg_row(input drbm_pkg::cfg_idx_t idx, input int data);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = drbm_pkg::cfg_data_t'(data);
    return r;
  endfunction

  // Drops the candidate valid, waits for every result and lets the block run dry.
  task automatic settle_block();
    cand_ch.valid <= 1'b0;
    if (busy) begin
      while (pending_matches.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      busy = 1'b0;
    end
  endtask

  task automatic write_reg(input drbm_pkg::cfg_idx_t idx, input drbm_pkg::cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      drbm_pkg::CFG_REF_CHARGE: ref_charge_r = data[1:0];
      drbm_pkg::CFG_REF_PHI:    ref_phi_r    = data[14:0];
      drbm_pkg::CFG_REF_ETA:    ref_eta_r    = data;
      drbm_pkg::CFG_REF_PT:     ref_pt_r     = data;
      drbm_pkg::CFG_TIE_TOL:    tie_tol_r    = data[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Valid stays high after the transfer so that the next call can follow on at once.
  task automatic send_candidate(input cand_t c, input bit typed, input match_t typed_want);
    int     gap;
    bit     closes;
    match_t m;
    gap = idle_len();
    if (gap > 0) begin
      cand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cand_ch.valid       <= 1'b1;
    cand_ch.cand_charge <= c.charge;
    cand_ch.cand_phi    <= c.phi;
    cand_ch.cand_eta    <= c.eta;
    cand_ch.cand_pt     <= c.pt;
    cand_ch.last        <= c.last;
    @(posedge clk);
    while (!cand_ch.ready) @(posedge clk);
    predict_match(c, m, closes);
    if (closes) pending_matches.push_back(typed ? typed_want : m);
    cands_sent++;
    busy = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (res_ch.ready) begin
      stall_len = idle_len();
      if (stall_len > 0) begin
        res_ch.ready <= 1'b0;
        ready_hold   <= stall_len - 1;
      end
    end else begin
      res_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_matches.size() == 0) begin
        flag_mismatch("result transfer with no expectation waiting");
      end else begin
        seen_want = pending_matches.pop_front();
        if (res_ch.found !== seen_want.found)
          flag_mismatch($sformatf("found %0b, wanted %0b", res_ch.found, seen_want.found));
        if (res_ch.best_index !== seen_want.index)
          flag_mismatch($sformatf("best_index %0d, wanted %0d", res_ch.best_index,
                                  seen_want.index));
        if (res_ch.best_dr !== seen_want.dr)
          flag_mismatch($sformatf("best_dr %0d, wanted %0d", res_ch.best_dr, seen_want.dr));
        if (res_ch.best_dpt !== seen_want.dpt)
          flag_mismatch($sformatf("best_dpt %0d, wanted %0d", res_ch.best_dpt, seen_want.dpt));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t                plan[$];
    cand_t               c;
    cand_t               prev;
    drbm_pkg::cfg_idx_t  widx;
    drbm_pkg::cfg_data_t wdata;
    int                  n_coll;
    int                  coll_len;
    int                  mode;
    bit                  long_run;
    bit                  long_done;

    cand_ch.valid       <= 1'b0;
    cand_ch.cand_charge <= '0;
    cand_ch.cand_phi    <= '0;
    cand_ch.cand_eta    <= '0;
    cand_ch.cand_pt     <= '0;
    cand_ch.last        <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= drbm_pkg::CFG_REF_CHARGE;
    cfg_ch.data         <= '0;
    prev      = '0;
    long_done = 1'b0;

    // Register defaults: charge 0, angles 0, pt 1, tie window 4.
    plan.push_back(typed_row(1, 0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(typed_row(0, 0, 0, 1, 1, 1, 0, 0, 0));
    plan.push_back(cand_row(0, 0, 0, 0, 0));
    plan.push_back(typed_row(-2, 0, 0, 0, 1, 1, 0, 0, -4096));
    plan.push_back(cand_row(-1, 0, 0, 1, 0));
    plan.push_back(typed_row(0, 0, 0, 65535, 1, 1, 1, 0, 8388607));
    // A zero reference pt behaves as one.
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_PT, 0));
    plan.push_back(typed_row(0, 0, 0, 0, 1, 1, 0, 0, -4096));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_CHARGE, -2));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_PHI, 12868));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_ETA, -32768));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_PT, 65535));
    plan.push_back(cfg_row(drbm_pkg::CFG_TIE_TOL, 0));
    plan.push_back(cand_row(-2, -12868, 32767, 0, 0));
    plan.push_back(cand_row(-2, 12868, -32768, 65535, 0));
    plan.push_back(cand_row(-2, 12868, -32768, 0, 0));
    plan.push_back(cand_row(-1, 0, 0, 0, 1));
    // Widest tie window: a close dR with a smaller dpt wins.
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_CHARGE, 1));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_PHI, -12868));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_ETA, 32767));
    plan.push_back(cfg_row(drbm_pkg::CFG_TIE_TOL, 255));
    plan.push_back(cand_row(1, -12868, 32767, 65535, 0));
    plan.push_back(cand_row(1, -12768, 32767, 0, 0));
    plan.push_back(cand_row(1, -12818, 32767, 65535, 0));
    plan.push_back(cand_row(1, 12868, 32767, 32768, 1));
    // Writes to unmapped indexes must leave the charge alone.
    plan.push_back(cfg_row(CFG_UNMAPPED_FIRST, 16'hFFFF));
    plan.push_back(cfg_row(CFG_UNMAPPED_LAST, 0));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_PHI, -16384));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_ETA, -32768));
    plan.push_back(cand_row(1, 16383, 32767, 1, 1));
    plan.push_back(cand_row(1, -16384, -32768, 100, 1));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_CHARGE, -1));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_PHI, 0));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_ETA, 0));
    plan.push_back(cfg_row(drbm_pkg::CFG_REF_PT, 1));
    plan.push_back(cfg_row(drbm_pkg::CFG_TIE_TOL, 4));
    plan.push_back(cand_row(-1, 12867, 1, 12345, 0));
    plan.push_back(cand_row(0, -1, -1, 0, 0));
    plan.push_back(cand_row(-1, -12867, -1, 2, 1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_block();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        cfg_ch.valid <= 1'b0;
        send_candidate(plan[i].cand, plan[i].typed, plan[i].want);
      end
    end

    while (cands_random < RANDOM_ITEMS) begin
      settle_block();
      no_stall = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 4)) begin
        widx = drbm_pkg::cfg_idx_t'($urandom_range(drbm_pkg::CFG_REF_CHARGE,
                                                   CFG_UNMAPPED_LAST));
        case (widx)
          drbm_pkg::CFG_REF_CHARGE: wdata = drbm_pkg::cfg_data_t'($urandom_range(0, 3));
          drbm_pkg::CFG_REF_PHI:
            wdata = ($urandom_range(0, 3) != 0) ?
                    drbm_pkg::cfg_data_t'($urandom_range(0, 2 * drbm_pkg::PI_Q) -
                                          drbm_pkg::PI_Q) :
                    drbm_pkg::cfg_data_t'($urandom);
          drbm_pkg::CFG_REF_PT: begin
            mode = $urandom_range(0, 15);
            wdata = (mode == 0) ? 16'd0 : (mode == 1) ? 16'd1 : (mode == 2) ? 16'hFFFF :
                    drbm_pkg::cfg_data_t'($urandom);
          end
          drbm_pkg::CFG_TIE_TOL: begin
            mode = $urandom_range(0, 7);
            wdata = (mode == 0) ? 16'd0 : (mode == 1) ? 16'd255 :
                    drbm_pkg::cfg_data_t'($urandom_range(0, 255));
          end
          default: wdata = drbm_pkg::cfg_data_t'($urandom);
        endcase
        write_reg(widx, wdata);
      end
      cfg_ch.valid <= 1'b0;

      // Once, half way, a collection that runs past the position counter's wrap.
      long_run = !long_done && cands_random >= RANDOM_ITEMS / 2;
      n_coll = $urandom_range(1, 4);
      repeat (n_coll) begin
        if (long_run) coll_len = 4100 + $urandom_range(0, 40);
        else if ($urandom_range(0, 7) == 0) coll_len = $urandom_range(20, 60);
        else coll_len = $urandom_range(1, 8);
        for (int k = 0; k < coll_len; k++) begin
          if (long_run && k < 4090)
            c.charge = ($urandom_range(0, 63) == 0) ? ref_charge_r : ref_charge_r + 2'd1;
          else if ($urandom_range(0, 3) != 0)
            c.charge = ref_charge_r;
          else
            c.charge = drbm_pkg::charge_t'($urandom_range(0, 3));
          mode = $urandom_range(0, 9);
          if (mode < 4) begin
            c.phi = ref_phi_r + drbm_pkg::phi_t'($urandom_range(0, 128) - 64);
            c.eta = ref_eta_r + drbm_pkg::eta_t'($urandom_range(0, 128) - 64);
          end else if (mode < 6) begin
            c.phi = prev.phi + drbm_pkg::phi_t'($urandom_range(0, 16) - 8);
            c.eta = prev.eta + drbm_pkg::eta_t'($urandom_range(0, 16) - 8);
          end else begin
            c.phi = drbm_pkg::phi_t'($urandom);
            c.eta = drbm_pkg::eta_t'($urandom);
          end
          mode = $urandom_range(0, 15);
          if (mode == 0) c.pt = '0;
          else if (mode == 1) c.pt = 16'hFFFF;
          else if (mode < 9) c.pt = ref_pt_r + drbm_pkg::pt_t'($urandom_range(0, 512) - 256);
          else c.pt = drbm_pkg::pt_t'($urandom);
          c.last = (k == coll_len - 1);
          send_candidate(c, 1'b0, '0);
          prev = c;
          if (!long_run) cands_random++;
        end
        if (long_run) begin
          long_run  = 1'b0;
          long_done = 1'b1;
        end
      end
    end

    settle_block();
    $display("tb: %0d candidates sent, %0d match results checked, %0d register writes",
             cands_sent, results_seen, reg_writes);
    $display("tb: covered charge mismatch, tie window, pt saturation, angle wrap, long stream");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
